[rtl/qgs_pkg.sv]
// ----------------------------------------------------------------------------
// qgs_pkg: shared types and constants of the quad grid subdivider
// Division count limits, register codes, reciprocal scaling and the sideband
// record that travels down the arithmetic pipeline with every grid point.
// ----------------------------------------------------------------------------
package qgs_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned DIV_W       = 3;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned WEIGHT_W    = 6;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned NUM_CORNERS = 4;
  localparam int unsigned NUM_AXES    = 3;

  localparam logic [DIV_W-1:0] MAX_DIVISIONS = 3'd7;

  // Reciprocal of 2*den is scaled by 2^RECIP_SHIFT.
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned RECIP_W     = 40;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_U_DIVISIONS = 1'b0,
    REG_V_DIVISIONS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  point_index;
    logic                quad_valid;
    logic [INDEX_W-1:0]  quad_corner_a;
    logic [INDEX_W-1:0]  quad_corner_b;
    logic [INDEX_W-1:0]  quad_corner_c;
    logic [INDEX_W-1:0]  quad_corner_d;
    logic                last_point;
    logic [WEIGHT_W-1:0] den;
  } side_t;

  // A count of zero acts as one, and counts above the limit are clamped.
  function automatic logic [DIV_W-1:0] eff_div(input logic [DIV_W-1:0] r);
    logic [DIV_W-1:0] d;
    d = r;
    if (d == '0) begin
      d = DIV_W'(1);
    end
    if (d > MAX_DIVISIONS) begin
      d = MAX_DIVISIONS;
    end
    return d;
  endfunction

endpackage

[rtl/qgs_quad_if.sv]
// ----------------------------------------------------------------------------
// qgs_quad_if: input channel of the quad grid subdivider
// One transaction carries the four corners of a quad in signed Q16.16.
// ----------------------------------------------------------------------------
interface qgs_quad_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] corner0_x;
  logic signed [31:0] corner0_y;
  logic signed [31:0] corner0_z;
  logic signed [31:0] corner1_x;
  logic signed [31:0] corner1_y;
  logic signed [31:0] corner1_z;
  logic signed [31:0] corner2_x;
  logic signed [31:0] corner2_y;
  logic signed [31:0] corner2_z;
  logic signed [31:0] corner3_x;
  logic signed [31:0] corner3_y;
  logic signed [31:0] corner3_z;

  modport source (
    output valid,
    input  ready,
    output corner0_x, corner0_y, corner0_z,
    output corner1_x, corner1_y, corner1_z,
    output corner2_x, corner2_y, corner2_z,
    output corner3_x, corner3_y, corner3_z
  );

  modport sink (
    input  valid,
    output ready,
    input  corner0_x, corner0_y, corner0_z,
    input  corner1_x, corner1_y, corner1_z,
    input  corner2_x, corner2_y, corner2_z,
    input  corner3_x, corner3_y, corner3_z
  );
endinterface

[rtl/qgs_point_if.sv]
// ----------------------------------------------------------------------------
// qgs_point_if: output channel of the quad grid subdivider
// One transaction carries one grid point and the sub-quad based at it.
// ----------------------------------------------------------------------------
interface qgs_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [5:0]         point_index;
  logic               quad_valid;
  logic [5:0]         quad_corner_a;
  logic [5:0]         quad_corner_b;
  logic [5:0]         quad_corner_c;
  logic [5:0]         quad_corner_d;
  logic               last_point;

  modport source (
    output valid,
    input  ready,
    output point_x, point_y, point_z, point_index, quad_valid,
    output quad_corner_a, quad_corner_b, quad_corner_c, quad_corner_d,
    output last_point
  );

  modport sink (
    input  valid,
    output ready,
    input  point_x, point_y, point_z, point_index, quad_valid,
    input  quad_corner_a, quad_corner_b, quad_corner_c, quad_corner_d,
    input  last_point
  );
endinterface

[rtl/quad_grid_subdivider.sv]
// ----------------------------------------------------------------------------
// quad_grid_subdivider: bilinear grid tessellation of one quad
// Walks the (U+1)x(V+1) grid of a quad and blends its corners into rounded
// Q16.16 grid points, each tagged with the local sub-quad based at it.
// ----------------------------------------------------------------------------
//
//  channel    | dir | handshake     | contents
//  -----------+-----+---------------+----------------------------------------
//  cfg        | in  | cfg_write     | cfg_index selects U or V, cfg_data value
//  quad_in    | in  | valid/ready   | corners 0..3, x/y/z, signed Q16.16
//  point_out  | out | valid/ready   | grid point, index, sub-quad, last flag
//
//  The grid walker issues one point per cycle while the output does not stall,
//  and takes the next quad only after issuing the final point.
//  Each point then passes the arithmetic pipeline stages in order (weights,
//  products, sum, magnitude, reciprocal partial products, quotient, remainder
//  product, correction). Reset clears the walker and all valid bits and sets
//  both division counts to one. A stalled output freezes the whole pipeline.
//
module quad_grid_subdivider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [qgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qgs_pkg::DIV_W-1:0]    cfg_data,
  qgs_quad_if.sink                     quad_in,
  qgs_point_if.source                  point_out
);
  import qgs_pkg::*;

  localparam int unsigned NUM_DEN   = 1 << WEIGHT_W;
  localparam int unsigned PROD_W    = COORD_W + WEIGHT_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned MAG_W     = COORD_W + WEIGHT_W + 1;
  localparam int unsigned HALF_R    = RECIP_W / 2;
  localparam int unsigned PP_W      = MAG_W + HALF_R;
  localparam int unsigned FULL_W    = MAG_W + RECIP_W;
  localparam int unsigned QUOT_W    = FULL_W - RECIP_SHIFT;
  localparam logic [RECIP_W:0] RECIP_ONE = (RECIP_W+1)'(1) << RECIP_SHIFT;

  // Configuration registers.
  logic [DIV_W-1:0] u_divisions;
  logic [DIV_W-1:0] v_divisions;

  always_ff @(posedge clk) begin
    if (rst) begin
      u_divisions <= DIV_W'(1);
      v_divisions <= DIV_W'(1);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_U_DIVISIONS: u_divisions <= cfg_data;
        REG_V_DIVISIONS: v_divisions <= cfg_data;
        default: ;
      endcase
    end
  end

  // Reciprocal table: floor(2^40 / (2*den)), worked out at elaboration.
  logic [RECIP_W-1:0] recip_tab [NUM_DEN];
  for (genvar g = 0; g < NUM_DEN; g++) begin : g_recip
    localparam logic [RECIP_W-1:0] R_G =
      RECIP_W'(RECIP_ONE / (2 * ((g == 0) ? 1 : g)));
    assign recip_tab[g] = R_G;
  end

  logic advance;
  assign advance = !point_out.valid || point_out.ready;

  // Grid walker.
  logic                busy;
  logic [DIV_W-1:0]    u_cnt, v_cnt, u_eff, v_eff;
  logic [INDEX_W-1:0]  idx_cnt;
  logic signed [COORD_W-1:0] corner [NUM_CORNERS][NUM_AXES];
  logic                emit, last_now, accept;

  assign quad_in.ready = !busy && advance;
  assign accept        = quad_in.valid && quad_in.ready;
  assign emit          = busy && advance;
  assign last_now      = (u_cnt == u_eff) && (v_cnt == v_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (emit && last_now) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      u_cnt   <= '0;
      v_cnt   <= '0;
      idx_cnt <= '0;
      u_eff   <= eff_div(u_divisions);
      v_eff   <= eff_div(v_divisions);
      corner[0][0] <= quad_in.corner0_x;
      corner[0][1] <= quad_in.corner0_y;
      corner[0][2] <= quad_in.corner0_z;
      corner[1][0] <= quad_in.corner1_x;
      corner[1][1] <= quad_in.corner1_y;
      corner[1][2] <= quad_in.corner1_z;
      corner[2][0] <= quad_in.corner2_x;
      corner[2][1] <= quad_in.corner2_y;
      corner[2][2] <= quad_in.corner2_z;
      corner[3][0] <= quad_in.corner3_x;
      corner[3][1] <= quad_in.corner3_y;
      corner[3][2] <= quad_in.corner3_z;
    end else if (emit) begin
      idx_cnt <= idx_cnt + INDEX_W'(1);
      if (u_cnt == u_eff) begin
        u_cnt <= '0;
        v_cnt <= v_cnt + DIV_W'(1);
      end else begin
        u_cnt <= u_cnt + DIV_W'(1);
      end
    end
  end

  // Stage 1: weights and sideband.
  logic [DIV_W-1:0]    u_rem, v_rem;
  logic                qv_now;
  side_t               side_now;
  logic [WEIGHT_W-1:0] w_now [NUM_CORNERS];

  always_comb begin
    u_rem    = u_eff - u_cnt;
    v_rem    = v_eff - v_cnt;
    w_now[0] = WEIGHT_W'(u_rem) * WEIGHT_W'(v_rem);
    w_now[1] = WEIGHT_W'(u_cnt) * WEIGHT_W'(v_rem);
    w_now[2] = WEIGHT_W'(u_cnt) * WEIGHT_W'(v_cnt);
    w_now[3] = WEIGHT_W'(u_rem) * WEIGHT_W'(v_cnt);
    qv_now   = (u_cnt != u_eff) && (v_cnt != v_eff);
    side_now.point_index   = idx_cnt;
    side_now.quad_valid    = qv_now;
    side_now.quad_corner_a = qv_now ? idx_cnt : '0;
    side_now.quad_corner_b = qv_now ? idx_cnt + INDEX_W'(1) : '0;
    side_now.quad_corner_c = qv_now ? idx_cnt + INDEX_W'(u_eff) + INDEX_W'(2) : '0;
    side_now.quad_corner_d = qv_now ? idx_cnt + INDEX_W'(u_eff) + INDEX_W'(1) : '0;
    side_now.last_point    = last_now;
    side_now.den           = WEIGHT_W'(u_eff) * WEIGHT_W'(v_eff);
  end

  logic                s1_valid, s2_valid, s3_valid, s4_valid;
  logic                s5_valid, s6_valid, s7_valid;
  side_t               s1_side, s2_side, s3_side, s4_side, s5_side, s6_side, s7_side;
  logic [WEIGHT_W-1:0] s1_w [NUM_CORNERS];

  logic signed [PROD_W-1:0] s2_prod [NUM_CORNERS][NUM_AXES];
  logic signed [SUM_W-1:0]  s3_sum [NUM_AXES];
  logic [NUM_AXES-1:0]      s4_neg, s5_neg, s6_neg, s7_neg;
  logic [MAG_W-1:0]         s4_m [NUM_AXES];
  logic [MAG_W-1:0]         s5_m [NUM_AXES];
  logic [MAG_W-1:0]         s6_m [NUM_AXES];
  logic [MAG_W-1:0]         s7_m [NUM_AXES];
  logic [PP_W-1:0]          s5_plo [NUM_AXES];
  logic [PP_W-1:0]          s5_phi [NUM_AXES];
  logic [QUOT_W-1:0]        s6_q0 [NUM_AXES];
  logic [QUOT_W-1:0]        s7_q0 [NUM_AXES];
  logic [MAG_W-1:0]         s7_back [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      s2_valid        <= 1'b0;
      s3_valid        <= 1'b0;
      s4_valid        <= 1'b0;
      s5_valid        <= 1'b0;
      s6_valid        <= 1'b0;
      s7_valid        <= 1'b0;
      point_out.valid <= 1'b0;
    end else if (advance) begin
      s1_valid        <= emit;
      s2_valid        <= s1_valid;
      s3_valid        <= s2_valid;
      s4_valid        <= s3_valid;
      s5_valid        <= s4_valid;
      s6_valid        <= s5_valid;
      s7_valid        <= s6_valid;
      point_out.valid <= s7_valid;
    end
  end

  // Payload registers; the corners are read while the quad's points pass
  // stage 1, and a new quad is only loaded on a cycle the pipeline moves.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_side <= side_now;
      s2_side <= s1_side;
      s3_side <= s2_side;
      s4_side <= s3_side;
      s5_side <= s4_side;
      s6_side <= s5_side;
      s7_side <= s6_side;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        s1_w[k] <= w_now[k];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
          s2_prod[k][a] <= PROD_W'(corner[k][a]) * PROD_W'($signed({1'b0, s1_w[k]}));
        end
        s3_sum[a] <= SUM_W'(s2_prod[0][a]) + SUM_W'(s2_prod[1][a])
                   + SUM_W'(s2_prod[2][a]) + SUM_W'(s2_prod[3][a]);
        // Magnitude of the rounding numerator: 2|n| + den.
        s4_neg[a] <= s3_sum[a][SUM_W-1];
        s4_m[a]   <= MAG_W'({(s3_sum[a][SUM_W-1] ? -s3_sum[a] : s3_sum[a]), 1'b0})
                   + MAG_W'(s3_side.den);
        s5_neg[a] <= s4_neg[a];
        s5_m[a]   <= s4_m[a];
        s5_plo[a] <= PP_W'(s4_m[a]) * PP_W'(recip_tab[s4_side.den][HALF_R-1:0]);
        s5_phi[a] <= PP_W'(s4_m[a]) * PP_W'(recip_tab[s4_side.den][RECIP_W-1:HALF_R]);
        s6_neg[a] <= s5_neg[a];
        s6_m[a]   <= s5_m[a];
        s6_q0[a]  <= QUOT_W'((FULL_W'(s5_plo[a]) + (FULL_W'(s5_phi[a]) << HALF_R))
                   >> RECIP_SHIFT);
        s7_neg[a]  <= s6_neg[a];
        s7_m[a]    <= s6_m[a];
        s7_q0[a]   <= s6_q0[a];
        s7_back[a] <= MAG_W'(s6_q0[a] * {s6_side.den, 1'b0});
      end
    end
  end

  // Final stage: the estimate is at most one low, so one compare fixes it.
  logic [QUOT_W-1:0]  q_fix [NUM_AXES];
  logic [COORD_W-1:0] q_out [NUM_AXES];
  logic [MAG_W-1:0]   rem   [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      rem[a]   = s7_m[a] - s7_back[a];
      q_fix[a] = s7_q0[a]
               + QUOT_W'(rem[a] >= MAG_W'({s7_side.den, 1'b0}));
      q_out[a] = s7_neg[a] ? -q_fix[a][COORD_W-1:0] : q_fix[a][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point_out.point_x       <= q_out[0];
      point_out.point_y       <= q_out[1];
      point_out.point_z       <= q_out[2];
      point_out.point_index   <= s7_side.point_index;
      point_out.quad_valid    <= s7_side.quad_valid;
      point_out.quad_corner_a <= s7_side.quad_corner_a;
      point_out.quad_corner_b <= s7_side.quad_corner_b;
      point_out.quad_corner_c <= s7_side.quad_corner_c;
      point_out.quad_corner_d <= s7_side.quad_corner_d;
      point_out.last_point    <= s7_side.last_point;
    end
  end

endmodule

[tb/sv/qgs_grid_checker.sv]
// ----------------------------------------------------------------------------
// qgs_grid_checker: grid point predictor and scoreboard
// Follows the division count writes, expands every accepted quad into its
// expected grid points and compares each accepted point field by field.
// ----------------------------------------------------------------------------
module qgs_grid_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [qgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qgs_pkg::DIV_W-1:0]       cfg_data,
  qgs_quad_if                             quad_mon,
  qgs_point_if                            point_mon,
  output int unsigned                     mismatches,
  output int unsigned                     outstanding
);
  import qgs_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [INDEX_W-1:0]        index;
    logic                      quad_valid;
    logic [INDEX_W-1:0]        corner_a;
    logic [INDEX_W-1:0]        corner_b;
    logic [INDEX_W-1:0]        corner_c;
    logic [INDEX_W-1:0]        corner_d;
    logic                      last;
  } grid_point_t;

  logic [DIV_W-1:0] u_cells_reg;
  logic [DIV_W-1:0] v_cells_reg;
  grid_point_t      expected_points[$];
  int unsigned      error_total;

  assign mismatches = error_total;

  task automatic report_mismatch(input string what);
    error_total++;
    $display("[%0t] grid checker: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input int unsigned index);
    if (got !== want) begin
      report_mismatch($sformatf("point %0d %s is %h, expected %h", index, name, got, want));
    end
  endtask

  // A count of zero behaves as a single cell; three bits cannot exceed the maximum.
  function automatic int active_cells(input logic [DIV_W-1:0] r);
    return (r == '0) ? 1 : int'(r);
  endfunction

  // Division rounded to nearest with ties away from zero; den is positive.
  function automatic logic signed [COORD_W-1:0] round_ratio(input longint num,
                                                            input longint den);
    longint q;
    if (num >= 0) begin
      q = (2 * num + den) / (2 * den);
    end else begin
      q = -((2 * (-num) + den) / (2 * den));
    end
    return q[COORD_W-1:0];
  endfunction

  task automatic predict_grid();
    longint                    corner [NUM_CORNERS][NUM_AXES];
    longint                    w [NUM_CORNERS];
    longint                    sum;
    logic signed [COORD_W-1:0] blended [NUM_AXES];
    int                        nu;
    int                        nv;
    grid_point_t               p;
    corner[0][0] = quad_mon.corner0_x;
    corner[0][1] = quad_mon.corner0_y;
    corner[0][2] = quad_mon.corner0_z;
    corner[1][0] = quad_mon.corner1_x;
    corner[1][1] = quad_mon.corner1_y;
    corner[1][2] = quad_mon.corner1_z;
    corner[2][0] = quad_mon.corner2_x;
    corner[2][1] = quad_mon.corner2_y;
    corner[2][2] = quad_mon.corner2_z;
    corner[3][0] = quad_mon.corner3_x;
    corner[3][1] = quad_mon.corner3_y;
    corner[3][2] = quad_mon.corner3_z;
    nu = active_cells(u_cells_reg);
    nv = active_cells(v_cells_reg);
    for (int v = 0; v <= nv; v++) begin
      for (int u = 0; u <= nu; u++) begin
        w[0] = (nu - u) * (nv - v);
        w[1] = u * (nv - v);
        w[2] = u * v;
        w[3] = (nu - u) * v;
        for (int a = 0; a < NUM_AXES; a++) begin
          sum = 0;
          for (int k = 0; k < NUM_CORNERS; k++) begin
            sum += corner[k][a] * w[k];
          end
          blended[a] = round_ratio(sum, nu * nv);
        end
        p            = '0;
        p.x          = blended[0];
        p.y          = blended[1];
        p.z          = blended[2];
        p.index      = INDEX_W'(v * (nu + 1) + u);
        p.quad_valid = (u < nu) && (v < nv);
        if (p.quad_valid) begin
          p.corner_a = p.index;
          p.corner_b = INDEX_W'(v * (nu + 1) + u + 1);
          p.corner_c = INDEX_W'(v * (nu + 1) + u + nu + 2);
          p.corner_d = INDEX_W'(v * (nu + 1) + u + nu + 1);
        end
        p.last = (u == nu) && (v == nv);
        expected_points = {expected_points, p};
      end
    end
  endtask

  always @(posedge clk) begin
    grid_point_t want;
    if (rst) begin
      u_cells_reg = DIV_W'(1);
      v_cells_reg = DIV_W'(1);
      expected_points.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_U_DIVISIONS) begin
          u_cells_reg = cfg_data;
        end else if (cfg_index == REG_V_DIVISIONS) begin
          v_cells_reg = cfg_data;
        end
      end
      // Points leave before a new quad is expanded, so queue order stays intact.
      if (point_mon.valid && point_mon.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("grid point transaction arrived with nothing expected");
        end else begin
          want = expected_points.pop_front();
          check_field("point_x", point_mon.point_x, want.x, want.index);
          check_field("point_y", point_mon.point_y, want.y, want.index);
          check_field("point_z", point_mon.point_z, want.z, want.index);
          check_field("point_index", point_mon.point_index, want.index, want.index);
          check_field("quad_valid", point_mon.quad_valid, want.quad_valid, want.index);
          check_field("quad_corner_a", point_mon.quad_corner_a, want.corner_a, want.index);
          check_field("quad_corner_b", point_mon.quad_corner_b, want.corner_b, want.index);
          check_field("quad_corner_c", point_mon.quad_corner_c, want.corner_c, want.index);
          check_field("quad_corner_d", point_mon.quad_corner_d, want.corner_d, want.index);
          check_field("last_point", point_mon.last_point, want.last, want.index);
        end
      end
      if (quad_mon.valid && quad_mon.ready) begin
        predict_grid();
      end
    end
    outstanding <= expected_points.size();
  end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: top level for the quad grid subdivider
// Writes division counts while the block is idle, feeds directed and random
// quads under several idle and stall patterns, and gives the final verdict
// from the mismatch count of the grid checker.
// ----------------------------------------------------------------------------
module testbench;
  import qgs_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 400000;
  localparam int unsigned TAIL_CYCLES       = 24;
  localparam int unsigned QUADS_PER_SETTING = 19;
  localparam int unsigned SEND_IDLE [4]     = '{0, 55, 0, 37};
  localparam int unsigned STALL [4]         = '{0, 0, 55, 37};

  localparam logic signed [COORD_W-1:0] MAXC = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] MINC = 32'sh80000000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t corner_vals_t [12];

  logic             clk;
  logic             rst;
  logic             cfg_write;
  cfg_reg_t         cfg_index;
  logic [DIV_W-1:0] cfg_data;
  int unsigned      send_idle_pct;
  int unsigned      stall_pct;
  int unsigned      cycle_count;
  int unsigned      mismatches;
  int unsigned      outstanding;

  qgs_quad_if  quad_ch();
  qgs_point_if point_ch();

  quad_grid_subdivider i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .quad_in   (quad_ch),
    .point_out (point_ch)
  );

  qgs_grid_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .quad_mon    (quad_ch),
    .point_mon   (point_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    point_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: return MAXC;
      1: return MINC;
      2, 3: return coord_t'($urandom_range(0, 80)) - 40;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic corner_vals_t random_set();
    corner_vals_t c;
    foreach (c[i]) begin
      c[i] = pick_coord();
    end
    return c;
  endfunction

  // x takes the corners as given; y and z see them permuted.
  function automatic corner_vals_t mirror_set(input coord_t a, input coord_t b,
                                              input coord_t c, input coord_t d);
    return '{a, d, b, b, c, a, c, b, d, d, a, c};
  endfunction

  task automatic drive_corners(input corner_vals_t c);
    quad_ch.corner0_x <= c[0];
    quad_ch.corner0_y <= c[1];
    quad_ch.corner0_z <= c[2];
    quad_ch.corner1_x <= c[3];
    quad_ch.corner1_y <= c[4];
    quad_ch.corner1_z <= c[5];
    quad_ch.corner2_x <= c[6];
    quad_ch.corner2_y <= c[7];
    quad_ch.corner2_z <= c[8];
    quad_ch.corner3_x <= c[9];
    quad_ch.corner3_y <= c[10];
    quad_ch.corner3_z <= c[11];
  endtask

  // Valid stays high into the next quad unless an idle cycle is drawn.
  task automatic send_quad(input corner_vals_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      quad_ch.valid <= 1'b0;
      @(posedge clk);
    end
    quad_ch.valid <= 1'b1;
    drive_corners(c);
    do @(posedge clk); while (!quad_ch.ready);
  endtask

  task automatic drain();
    quad_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_divisions(input int unsigned u, input int unsigned v);
    cfg_write <= 1'b1;
    cfg_index <= REG_U_DIVISIONS;
    cfg_data  <= DIV_W'(u);
    @(posedge clk);
    cfg_index <= REG_V_DIVISIONS;
    cfg_data  <= DIV_W'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int unsigned ph;
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= REG_U_DIVISIONS;
    cfg_data       <= '0;
    quad_ch.valid  <= 1'b0;
    drive_corners(mirror_set(0, 0, 0, 0));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_divisions(1, 1);
    send_quad(mirror_set(MAXC, MAXC, MAXC, MAXC));
    send_quad(mirror_set(MINC, MINC, MINC, MINC));
    send_quad(mirror_set(MINC, MAXC, MINC, MAXC));
    send_quad(mirror_set(0, 0, 0, 0));
    drain();
    // Midpoints of 0 and 1 or -1 are exact halves and must round away from zero.
    set_divisions(2, 1);
    send_quad(mirror_set(0, 1, 1, 0));
    send_quad(mirror_set(0, -1, -1, 0));
    send_quad(mirror_set(MAXC, MINC, MINC, MAXC));
    drain();
    set_divisions(3, 3);
    send_quad(mirror_set(0, 1, 2, -1));
    send_quad(mirror_set(-3, 5, -7, 2));
    drain();
    // Zero division counts behave as one cell.
    set_divisions(0, 0);
    send_quad(random_set());
    drain();
    set_divisions(7, 0);
    send_quad(random_set());
    drain();
    set_divisions(0, 7);
    send_quad(random_set());
    drain();
    set_divisions(7, 7);
    send_quad(mirror_set(MAXC, MINC, MAXC, MINC));
    send_quad(mirror_set(MINC, MAXC, MAXC, MINC));
    send_quad(random_set());
    drain();

    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      stall_pct     = STALL[ph];
      for (int s = 0; s < 4; s++) begin
        set_divisions($urandom_range(0, 7), $urandom_range(0, 7));
        repeat (QUADS_PER_SETTING) send_quad(random_set());
        drain();
      end
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
